FILE: rtl/sfr_pkg.sv
// shared types and constants for the serial frame receiver
// no dependencies; imported by every module of the block
package sfr_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CH_W        = 11;
	localparam int unsigned IDX_W       = 5;
	localparam int unsigned NUM_PROP_CH = 16;
	// window slots 0..23 are kept; slot 24 is only ever compared on entry
	localparam int unsigned WIN_KEEP    = 24;
	localparam int unsigned CH_BITS     = NUM_PROP_CH * CH_W;

	localparam logic [BYTE_W-1:0] START_BYTE  = 8'h0F;
	localparam logic [BYTE_W-1:0] END_BYTE    = 8'h00;
	localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd50;
	localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'hFF;

	localparam logic [IDX_W-1:0] FLAG_HI_CH = 5'd16;
	localparam logic [IDX_W-1:0] FLAG_LO_CH = 5'd17;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// one queued burst: a decoded frame or a timeout marker
	typedef struct packed {
		logic               tmo;
		logic [1:0]         flags;      // [1] bit 7, [0] bit 6 of slot 23
		logic [CH_BITS-1:0] chan_bits;  // slots 1..22, lsb first
	} sfr_entry_t;

	typedef struct packed {
		logic       valid;
		sfr_entry_t entry;
	} sfr_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sfr_qstat_t;

endpackage

FILE: rtl/sfr_front.sv
// front end: byte window, search counter, frame and timeout detection
// depends on sfr_pkg; feeds sfr_queue
module sfr_front
	import sfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] search_limit,
	output sfr_push_t         push
);

	logic [BYTE_W-1:0] win_q [WIN_KEEP];
	logic [BYTE_W-1:0] count_q;
	logic [BYTE_W-1:0] count_next;
	logic              frame_hit;
	logic              tmo_hit;
	logic              clear;

	assign count_next = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;
	assign frame_hit  = (win_q[0] == START_BYTE) && (rx_byte == END_BYTE);
	// a limit of zero behaves as one since count_next is never zero
	assign tmo_hit    = !frame_hit && (count_next >= search_limit);
	assign clear      = frame_hit || tmo_hit;

	always_comb begin
		push.valid           = accept && clear;
		push.entry.tmo       = !frame_hit;
		push.entry.flags     = {win_q[WIN_KEEP-1][7], win_q[WIN_KEEP-1][6]};
		for (int i = 0; i < CH_BITS / BYTE_W; i++) begin
			push.entry.chan_bits[i*BYTE_W +: BYTE_W] = win_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < WIN_KEEP; i++) win_q[i] <= '0;
		end else if (accept) begin
			if (clear) begin
				count_q <= '0;
				for (int i = 0; i < WIN_KEEP; i++) win_q[i] <= '0;
			end else begin
				count_q <= count_next;
				for (int i = 0; i < WIN_KEEP - 1; i++) win_q[i] <= win_q[i+1];
				win_q[WIN_KEEP-1] <= rx_byte;
			end
		end
	end

endmodule

FILE: rtl/sfr_queue.sv
// short burst queue between front and back end
// depends on sfr_pkg
module sfr_queue
	import sfr_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  sfr_push_t  push,
	input  logic       pop,
	output sfr_entry_t head,
	output sfr_qstat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sfr_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

FILE: rtl/sfr_back.sv
// back end: walks the queue head and emits one result per cycle while the queue holds an entry and out_ready is high
// depends on sfr_pkg; reads from sfr_queue
module sfr_back
	import sfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sfr_entry_t        head,
	input  sfr_qstat_t        stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  channel_index,
	output logic [CH_W-1:0]   channel_value,
	output logic              search_timeout,
	output logic              last
);

	logic [IDX_W-1:0] ch_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [CH_W-1:0]  val_q;
	logic             tmo_q;
	logic             last_q;
	logic             produce;
	logic             res_last;
	logic [CH_W-1:0]  res_val;

	assign produce  = !stat.empty && (!out_valid_q || out_ready);
	assign res_last = head.tmo || (ch_q == FLAG_LO_CH);
	assign pop      = produce && res_last;

	always_comb begin
		if (head.tmo) begin
			res_val = '0;
		end else if (ch_q == FLAG_HI_CH) begin
			res_val = {{(CH_W-1){1'b0}}, head.flags[1]};
		end else if (ch_q == FLAG_LO_CH) begin
			res_val = {{(CH_W-1){1'b0}}, head.flags[0]};
		end else begin
			res_val = head.chan_bits[CH_W*ch_q[3:0] +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) begin
				out_valid_q <= 1'b1;
				ch_q        <= res_last ? '0 : ch_q + IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			idx_q  <= head.tmo ? '0 : ch_q;
			val_q  <= res_val;
			tmo_q  <= head.tmo;
			last_q <= res_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign channel_index  = idx_q;
	assign channel_value  = val_q;
	assign search_timeout = tmo_q;
	assign last           = last_q;

endmodule

FILE: rtl/sbus_frame_receiver_unit.sv
// top level of the serial frame receiver: config register, front, queue, back
// depends on sfr_pkg, sfr_front, sfr_queue, sfr_back
//
// usage
//  - input channel in_valid/in_ready carries one received byte (rx_byte) per
//    transaction; one byte can be taken every cycle while the queue is not full
//  - output channel out_valid/out_ready carries one result per transaction:
//    channel_index, channel_value, search_timeout and last
//  - cfg_wr_en/cfg_wr_data write search_limit (reset 50)
//  - a byte that completes a frame queues a burst of 18 results (16 packed
//    channels, then the two flag channels, last on channel 17); reaching the
//    search limit without a frame queues one timeout result instead
//  - the first result of a burst passes through its queue entry and then the
//    output register; a burst then runs at one result per cycle while out_ready
//    is high, so the rate is set by the output register draining the queue head
//  - throughput: one byte per cycle while the burst queue (QUEUE_DEPTH
//    entries) has room; in_ready falls only when the queue is full
//  - a stalled receiver holds the output register; bytes keep flowing until
//    the queue fills
//  - reset clears the window, the byte count and the queue, and sets the
//    search limit to 50; no clearing pass is needed
module sbus_frame_receiver_unit
	import sfr_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  channel_index,
	output logic [CH_W-1:0]   channel_value,
	output logic              search_timeout,
	output logic              last
);

	logic [BYTE_W-1:0] limit_q;
	logic              accept;
	sfr_push_t         push;
	sfr_entry_t        head;
	sfr_qstat_t        stat;
	logic              pop;

	// search limit register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// a byte is taken whenever the queue can hold a possible burst entry
	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;

	sfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.search_limit (limit_q),
		.push         (push)
	);

	sfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	sfr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.stat           (stat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.channel_index  (channel_index),
		.channel_value  (channel_value),
		.search_timeout (search_timeout),
		.last           (last)
	);

	// a timeout result is a lone, zeroed, final result
	a_tmo_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && search_timeout) |->
			(last && channel_index == '0 && channel_value == '0))
		else $error("timeout result malformed");

	// a frame burst closes only on the second flag channel
	a_last_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && !search_timeout) |-> (channel_index == FLAG_LO_CH))
		else $error("frame burst ended early");

	// mid-burst results follow back to back with rising channel numbers
	a_burst_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=>
			(out_valid && channel_index == $past(channel_index) + IDX_W'(1)))
		else $error("burst broken");

	// nothing is pushed while the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !accept)
		else $error("byte taken with full queue");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the serial frame receiver: bytes in, decoded channels out
// depends on sfr_pkg and sbus_frame_receiver_unit; reads no files, needs no arguments
module testbench;
	import sfr_pkg::*;

	localparam int WINDOW_LEN    = WIN_KEEP + 1;
	localparam int PAYLOAD_LEN   = 22;
	localparam int FLAG_SLOT     = WINDOW_LEN - 2;
	localparam int FLAG_HI_BIT   = 7;
	localparam int FLAG_LO_BIT   = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam int MAX_REPORTS   = 40;

	typedef logic [BYTE_W-1:0] byte_t;

	// one decoded result as it leaves the block
	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CH_W-1:0]  value;
		logic             tmo;
		logic             lst;
	} chan_result_t;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;
	typedef enum {SINK_OPEN, SINK_THIRD, SINK_HALF, SINK_MOSTLY} sink_mode_t;

	// frame decoder model plus the queue of decoded channels still owed by the block
	class frame_scoreboard;
		byte_t        window [WINDOW_LEN];
		byte_t        count;
		byte_t        limit;
		chan_result_t awaited [$];
		int           errors;

		function new();
			clear_window();
			limit  = LIMIT_RESET;
			errors = 0;
		endfunction

		function void clear_window();
			foreach (window[i]) window[i] = '0;
			count = '0;
		endfunction

		function void set_limit(byte_t v);
			limit = v;
		endfunction

		// channels sit lsb first from slot 1 onwards, 11 bits each
		function logic [CH_W-1:0] unpack_channel(int ch);
			logic [CH_W-1:0] v;
			int              pos;
			v = '0;
			for (int b = 0; b < CH_W; b++) begin
				pos  = ch * CH_W + b;
				v[b] = window[1 + pos / BYTE_W][pos % BYTE_W];
			end
			return v;
		endfunction

		// accepted input transaction: slide the window and queue what it decodes to
		function void note_byte(byte_t b);
			chan_result_t r;
			for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] = window[i + 1];
			window[WINDOW_LEN - 1] = b;
			if (count != COUNT_MAX) count++;
			if (window[0] == START_BYTE && window[WINDOW_LEN - 1] == END_BYTE) begin
				for (int ch = 0; ch < NUM_PROP_CH; ch++) begin
					r = '{index: IDX_W'(ch), value: unpack_channel(ch), tmo: 1'b0, lst: 1'b0};
					awaited.push_back(r);
				end
				r = '{index: FLAG_HI_CH, value: CH_W'(window[FLAG_SLOT][FLAG_HI_BIT]),
					tmo: 1'b0, lst: 1'b0};
				awaited.push_back(r);
				r = '{index: FLAG_LO_CH, value: CH_W'(window[FLAG_SLOT][FLAG_LO_BIT]),
					tmo: 1'b0, lst: 1'b1};
				awaited.push_back(r);
				clear_window();
			end else if (count >= limit) begin
				// a limit of zero falls in here on every byte, same as a limit of one
				r = '{index: '0, value: '0, tmo: 1'b1, lst: 1'b1};
				awaited.push_back(r);
				clear_window();
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		// accepted output transaction against the oldest awaited result
		function void check_result(chan_result_t got);
			chan_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with nothing awaited, expected none actual index %0d value %0d",
						$time, got.index, got.value);
				return;
			end
			want = awaited.pop_front();
			compare_field("channel_index", want.index, got.index);
			compare_field("channel_value", want.value, got.value);
			compare_field("search_timeout", want.tmo, got.tmo);
			compare_field("last", want.lst, got.lst);
		endfunction
	endclass

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              cfg_wr_en      = 1'b0;
	logic [BYTE_W-1:0] cfg_wr_data    = '0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] rx_byte        = '0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [IDX_W-1:0]  channel_index;
	logic [CH_W-1:0]   channel_value;
	logic              search_timeout;
	logic              last;

	frame_scoreboard sb = new();

	// sender burst bookkeeping and the request count for long receiver hold-offs
	int burst_left = 0;
	int hold_req   = 0;
	int cycles     = 0;

	sbus_frame_receiver_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.channel_index  (channel_index),
		.channel_value  (channel_value),
		.search_timeout (search_timeout),
		.last           (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result monitor: every output transaction goes straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{index: channel_index, value: channel_value,
				tmo: search_timeout, lst: last});
	end

	// receiver: its own stall pattern in a randomly switched mode, plus long
	// hold-offs counted here whenever the stimulus raises hold_req
	sink_mode_t sink_mode = SINK_OPEN;
	int         sink_tick = 0;
	int         hold_seen = 0;
	int         hold_left = 0;

	always @(posedge clk) begin
		sink_tick++;
		if (sink_tick % 60 == 0)
			sink_mode = sink_mode_t'($urandom_range(0, 3));
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN:   out_ready <= 1'b1;
				SINK_THIRD:  out_ready <= (sink_tick % 3 == 0);
				SINK_HALF:   out_ready <= $urandom_range(0, 1);
				default:     out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// one input transaction; a new burst may open with an idle gap, and now and
	// then a long burst runs with no gaps at all
	task automatic send_byte(input byte_t b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_byte(byte_t'($urandom));
	endtask

	// start byte, 22 payload bytes, flag byte, end byte, after optional noise
	task automatic send_frame(input int noise, input byte_t flag_byte, input byte_t end_byte,
		input fill_t fill);
		send_noise(noise);
		send_byte(START_BYTE);
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			case (fill)
				FILL_ZERO: send_byte('0);
				FILL_ONES: send_byte('1);
				default:   send_byte(byte_t'($urandom));
			endcase
		end
		send_byte(flag_byte);
		send_byte(end_byte);
	endtask

	// sender pauses until every awaited result is in, then lets the block settle
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// the search limit only changes while the block is idle
	task automatic write_limit(input byte_t v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(v);
	endtask

	// random traffic under one limit: mostly whole frames with random content,
	// some with a bad end byte, the rest bursts of noise
	task automatic run_phase(input byte_t lim, input int target, input bit pressure);
		int    sent;
		int    pick;
		int    noise;
		byte_t end_b;
		write_limit(lim);
		if (pressure)
			hold_req <= hold_req + 1;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				noise = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
				end_b = (pick == 0) ? byte_t'($urandom_range(1, 255)) : END_BYTE;
				send_frame(noise, byte_t'($urandom), end_b, FILL_RANDOM);
				sent += noise + WINDOW_LEN;
			end else begin
				noise = $urandom_range(1, 12);
				send_noise(noise);
				sent += noise;
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: all-zero and all-one payloads, each flag bit alone
		send_frame(0, 8'h00, END_BYTE, FILL_ZERO);
		send_frame(0, 8'hFF, END_BYTE, FILL_ONES);
		send_frame(0, 8'h80, END_BYTE, FILL_RANDOM);
		send_frame(2, 8'h40, END_BYTE, FILL_RANDOM);
		// start bytes that never close a frame run into the timeout
		repeat (50) send_byte(START_BYTE);

		// frame completes on the very byte that reaches the limit: frame wins
		write_limit(8'd25);
		send_frame(0, byte_t'($urandom), END_BYTE, FILL_RANDOM);

		// limit too short to ever hold a whole frame after a clear
		write_limit(8'd24);
		send_frame(0, byte_t'($urandom), END_BYTE, FILL_RANDOM);

		// every byte times out; the receiver holds off meanwhile, so the burst
		// queue fills and the input stalls while the sender keeps offering
		write_limit(8'd1);
		hold_req <= hold_req + 1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(START_BYTE);
		repeat (5) send_byte(byte_t'($urandom));

		// zero limit behaves like one
		write_limit(8'd0);
		send_byte(byte_t'($urandom));
		send_byte(END_BYTE);

		// random part; the first phase starts with another long receiver hold-off
		run_phase(8'd255, 15, 1'b1);
		run_phase(byte_t'($urandom_range(26, 254)), 15, 1'b0);
		run_phase(8'd30, 10, 1'b0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/sbus_frame_receiver_unit.sv
tb/testbench.sv
